// ===== design/fltpe_pkg.sv =====
`default_nettype none
package fltpe_pkg;

    localparam int IDX_W   = 9;
    localparam int OFS_W   = 12;
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FRAME_W = PA_W - OFS_W;
    localparam int ENT_W   = PA_W;

    localparam logic [2:0] REQ_MAP       = 3'd0;
    localparam logic [2:0] REQ_UNMAP     = 3'd1;
    localparam logic [2:0] REQ_TRANSLATE = 3'd2;
    localparam logic [2:0] REQ_SET       = 3'd3;
    localparam logic [2:0] REQ_CLEAR     = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OVERWRITE   = 2'd1;
    localparam logic [1:0] ST_NOT_MAPPED  = 2'd2;
    localparam logic [1:0] ST_OUT_OF_TBLS = 2'd3;

    typedef logic [ENT_W-1:0] entry_t;

    function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        unique case (lvl)
            2'd0: r = va[47:39];
            2'd1: r = va[38:30];
            2'd2: r = va[29:21];
            default: r = va[20:12];
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/fltpe_if.sv =====
`default_nettype none
interface fltpe_req_if
    import fltpe_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [2:0]      req_type;
    logic [VA_W-1:0] virt_addr;
    logic [PA_W-1:0] phys_addr;
    logic [11:0]     flag_bits;
    modport source (output valid, req_type, virt_addr, phys_addr, flag_bits, input ready);
    modport sink   (input valid, req_type, virt_addr, phys_addr, flag_bits, output ready);
endinterface

interface fltpe_rsp_if
    import fltpe_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [PA_W-1:0] phys_out;
    logic            mapped;
    logic [1:0]      status;
    modport source (output valid, phys_out, mapped, status, input ready);
    modport sink   (input valid, phys_out, mapped, status, output ready);
endinterface
`default_nettype wire

// ===== design/fltpe_ram.sv =====
`default_nettype none
module fltpe_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/four_level_page_table_engine.sv =====
// channel | dir | payload                                     | accepted when
// req     | in  | req_type, virt_addr, phys_addr, flag_bits   | valid && ready
// rsp     | out | phys_out, mapped, status                    | valid && ready
//
// a request passes through a read and an evaluate state (S_READ, S_EVAL) per
// level, between the accept in S_IDLE and the result in S_DONE
// after reset the table memory is cleared to zero while req.ready is low
// one request at a time; a finished result sits in the output register while
// the next request is accepted, a stalled rsp holds the walk in its last step
`default_nettype none
module four_level_page_table_engine
    import fltpe_pkg::*;
#(
    parameter int NUM_TABLES = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fltpe_req_if.sink   req,
    fltpe_rsp_if.source rsp
);
    localparam int TW    = $clog2(NUM_TABLES);
    localparam int DEPTH = NUM_TABLES << IDX_W;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_DONE} state_t;

    state_t           state_reg;
    logic [1:0]       lvl_reg;
    logic [TW-1:0]    cur_reg;
    logic [TW:0]      free_reg;
    logic [AW-1:0]    clr_reg;
    logic [2:0]       type_reg;
    logic [VA_W-1:0]  va_reg;
    logic [PA_W-1:0]  pa_reg;
    logic [11:0]      fm_reg;
    logic [PA_W-1:0]  res_phys_reg;
    logic             res_mapped_reg;
    logic [1:0]       res_status_reg;
    logic             out_valid_reg;
    logic [PA_W-1:0]  out_phys_reg;
    logic             out_mapped_reg;
    logic [1:0]       out_status_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    walk_addr;
    entry_t           ent;

    logic             present;
    logic             in_pool;
    logic             is_map;
    logic             out_load;
    logic             ev_descend;
    logic [TW-1:0]    ev_next_cur;
    logic             ev_alloc;
    logic             ev_done;
    logic [PA_W-1:0]  ev_phys;
    logic             ev_mapped;
    logic [1:0]       ev_status;

    fltpe_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (walk_addr),
        .rdata (ent)
    );

    assign walk_addr = AW'({cur_reg, level_index(va_reg, lvl_reg)});
    assign present   = ent[0];
    assign in_pool   = ent[PA_W-1:OFS_W] < FRAME_W'(NUM_TABLES);
    assign is_map    = (type_reg == REQ_MAP);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = walk_addr;
        ram_wdata   = '0;
        ev_descend  = 1'b0;
        ev_next_cur = ent[OFS_W +: TW];
        ev_alloc    = 1'b0;
        ev_done     = 1'b0;
        ev_phys     = '0;
        ev_mapped   = 1'b0;
        ev_status   = ST_OK;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
        end
        else if (state_reg == S_EVAL)
        begin
            if (lvl_reg != 2'd3)
            begin
                if (present && in_pool)
                begin
                    ev_descend = 1'b1;
                end
                else if (present || !is_map)
                begin
                    ev_done   = 1'b1;
                    ev_status = is_map ? ST_OUT_OF_TBLS : ST_NOT_MAPPED;
                end
                else if (free_reg == (TW+1)'(NUM_TABLES))
                begin
                    ev_done   = 1'b1;
                    ev_status = ST_OUT_OF_TBLS;
                end
                else
                begin
                    ev_descend  = 1'b1;
                    ev_alloc    = 1'b1;
                    ev_next_cur = free_reg[TW-1:0];
                    ram_we      = 1'b1;
                    ram_wdata   = entry_t'({FRAME_W'(free_reg), 12'h003});
                end
            end
            else
            begin
                ev_done = 1'b1;
                if (is_map)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {pa_reg[PA_W-1:OFS_W], fm_reg[11:1], 1'b1};
                    ev_mapped = 1'b1;
                    ev_status = present ? ST_OVERWRITE : ST_OK;
                end
                else if (!present)
                begin
                    ev_status = ST_NOT_MAPPED;
                end
                else
                begin
                    ev_mapped = 1'b1;
                    priority case (type_reg)
                        REQ_UNMAP:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = '0;
                        end
                        REQ_TRANSLATE:
                        begin
                            ev_phys = {ent[PA_W-1:OFS_W], va_reg[OFS_W-1:0]};
                        end
                        REQ_SET:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ent | entry_t'(fm_reg);
                        end
                        default:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ent & ~entry_t'(fm_reg);
                        end
                    endcase
                end
            end
        end
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.phys_out = out_phys_reg;
    assign rsp.mapped   = out_mapped_reg;
    assign rsp.status   = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            lvl_reg        <= '0;
            cur_reg        <= '0;
            free_reg       <= (TW+1)'(1);
            clr_reg        <= '0;
            type_reg       <= REQ_MAP;
            va_reg         <= '0;
            pa_reg         <= '0;
            fm_reg         <= '0;
            res_phys_reg   <= '0;
            res_mapped_reg <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_phys_reg   <= '0;
            out_mapped_reg <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        type_reg       <= req.req_type;
                        va_reg         <= req.virt_addr;
                        pa_reg         <= req.phys_addr;
                        fm_reg         <= req.flag_bits;
                        lvl_reg        <= '0;
                        cur_reg        <= '0;
                        res_phys_reg   <= '0;
                        res_mapped_reg <= 1'b0;
                        res_status_reg <= ST_OK;
                        state_reg      <= (req.req_type > REQ_CLEAR) ? S_DONE : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (ev_alloc)
                    begin
                        free_reg <= free_reg + (TW+1)'(1);
                    end
                    if (ev_descend)
                    begin
                        cur_reg   <= ev_next_cur;
                        lvl_reg   <= lvl_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                    if (ev_done)
                    begin
                        res_phys_reg   <= ev_phys;
                        res_mapped_reg <= ev_mapped;
                        res_status_reg <= ev_status;
                        state_reg      <= S_DONE;
                    end
                end
                default:
                begin
                    if (out_load)
                    begin
                        out_phys_reg   <= res_phys_reg;
                        out_mapped_reg <= res_mapped_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/fltpe_chk.sv =====
`default_nettype none
module fltpe_chk
    import fltpe_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic [PA_W-1:0] phys_out,
    input wire logic            mapped,
    input wire logic [1:0]      status
);
    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phys_out) && $stable(status))
        else $error("result changed while stalled");

    a_mapped_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mapped |-> status == ST_OK || status == ST_OVERWRITE)
        else $error("mapped with failure status");

    a_not_mapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NOT_MAPPED |-> !mapped && phys_out == '0)
        else $error("not mapped result carries data");

    a_oot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OUT_OF_TBLS |-> !mapped && phys_out == '0)
        else $error("out of tables result carries data");
endmodule

bind four_level_page_table_engine fltpe_chk u_fltpe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .phys_out  (rsp.phys_out),
    .mapped    (rsp.mapped),
    .status    (rsp.status)
);
`default_nettype wire

// ===== sim/four_level_page_table_engine_tb.sv =====
module four_level_page_table_engine_tb
    import fltpe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_TBL = 16;
    localparam logic [2:0] REQ_BAD = 3'd5;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic            mapped;
        logic [1:0]      status;
    } walk_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fltpe_req_if req ();
    fltpe_rsp_if rsp ();

    four_level_page_table_engine #(.NUM_TABLES(N_TBL)) dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // shadow page tables
    logic [63:0]  pt_mem [N_TBL*512];
    logic         pt_used [N_TBL];
    walk_result_t expected_walks [$];
    int           errors = 0;
    int           beats_sent = 0;
    int           beats_checked = 0;
    int           n_overwrite = 0;
    int           n_not_mapped = 0;
    int           n_out_of_tables = 0;
    int           hold_off = 0;
    bit           drain_stall_on = 1'b1;
    logic [VA_W-1:0] va_pool [$];

    function automatic logic [8:0] va_idx(logic [VA_W-1:0] va, int lvl);
        return 9'((va >> (39 - 9 * lvl)) & 48'h1FF);
    endfunction

    function automatic int next_table(logic [63:0] e);
        logic [63:0] t;
        if (!e[0])
            return -1;
        t = (e & 64'hFFFFFFFFFF000) >> 12;
        if (t >= N_TBL)
            return -1;
        return int'(t);
    endfunction

    function automatic walk_result_t predict_walk(logic [2:0] op, logic [VA_W-1:0] va,
                                                  logic [PA_W-1:0] pa, logic [11:0] fm);
        walk_result_t r;
        int cur;
        int nxt;
        int li;
        bit ok;
        r = '0;
        cur = 0;
        ok = 1'b1;
        if (op == REQ_MAP)
        begin
            for (int lvl = 0; lvl < 3; lvl++)
            begin
                li = cur * 512 + va_idx(va, lvl);
                if (!pt_mem[li][0])
                begin
                    nxt = -1;
                    for (int t = 1; t < N_TBL; t++)
                    begin
                        if (nxt < 0 && !pt_used[t])
                            nxt = t;
                    end
                    if (nxt < 0)
                    begin
                        ok = 1'b0;
                        break;
                    end
                    pt_used[nxt] = 1'b1;
                    pt_mem[li] = (64'(nxt) << 12) | 64'h3;
                end
                else
                begin
                    nxt = next_table(pt_mem[li]);
                    if (nxt < 0)
                    begin
                        ok = 1'b0;
                        break;
                    end
                end
                cur = nxt;
            end
            if (!ok)
                r.status = ST_OUT_OF_TBLS;
            else
            begin
                li = cur * 512 + va_idx(va, 3);
                r.status = pt_mem[li][0] ? ST_OVERWRITE : ST_OK;
                pt_mem[li] = 64'(pa & 52'hFFFFFFFFFF000) | 64'(fm) | 64'h1;
                r.mapped = 1'b1;
            end
        end
        else if (op <= REQ_CLEAR)
        begin
            for (int lvl = 0; lvl < 3; lvl++)
            begin
                nxt = next_table(pt_mem[cur * 512 + va_idx(va, lvl)]);
                if (nxt < 0)
                begin
                    ok = 1'b0;
                    break;
                end
                cur = nxt;
            end
            li = cur * 512 + va_idx(va, 3);
            if (!ok || !pt_mem[li][0])
                r.status = ST_NOT_MAPPED;
            else
            begin
                r.mapped = 1'b1;
                case (op)
                    REQ_UNMAP:     pt_mem[li] = '0;
                    REQ_TRANSLATE: r.pa = PA_W'(pt_mem[li] & 64'hFFFFFFFFFF000) | PA_W'(va[11:0]);
                    REQ_SET:       pt_mem[li] = pt_mem[li] | 64'(fm);
                    default:       pt_mem[li] = pt_mem[li] & ~64'(fm);
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_request(logic [2:0] op, logic [VA_W-1:0] va,
                                logic [PA_W-1:0] pa, logic [11:0] fm);
        walk_result_t r;
        req.valid     <= 1'b1;
        req.req_type  <= op;
        req.virt_addr <= va;
        req.phys_addr <= pa;
        req.flag_bits <= fm;
        do
            @(posedge clk);
        while (!req.ready);
        r = predict_walk(op, va, pa, fm);
        expected_walks.push_back(r);
        beats_sent++;
        case (r.status)
            ST_OVERWRITE:   n_overwrite++;
            ST_NOT_MAPPED:  n_not_mapped++;
            ST_OUT_OF_TBLS: n_out_of_tables++;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_walks.size() != 0)
            @(negedge clk);
    endtask

    // response checker
    always @(posedge clk)
    begin
        walk_result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            beats_checked++;
            if (expected_walks.size() == 0)
            begin
                $display("%0t: unexpected beat pa=%h mapped=%b status=%0d", $realtime,
                         rsp.phys_out, rsp.mapped, rsp.status);
                errors++;
            end
            else
            begin
                e = expected_walks.pop_front();
                if (rsp.phys_out !== e.pa)
                begin
                    $display("%0t: phys_out expected %h actual %h", $realtime, e.pa, rsp.phys_out);
                    errors++;
                end
                if (rsp.mapped !== e.mapped)
                begin
                    $display("%0t: mapped expected %b actual %b", $realtime, e.mapped, rsp.mapped);
                    errors++;
                end
                if (rsp.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                             rsp.status);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int phase;
        rsp.ready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                rsp.ready <= 1'b0;
            end
            else if (!drain_stall_on)
                rsp.ready <= 1'b1;
            else
            begin
                phase = (phase + 1) % 64;
                if (phase < 24)
                    rsp.ready <= 1'b1;
                else
                    rsp.ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    function automatic logic [VA_W-1:0] rand_va();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [PA_W-1:0] rand_pa();
        return {20'($urandom), $urandom};
    endfunction

    task automatic test_directed();
        logic [VA_W-1:0] va_top;
        va_top = '1;
        send_request(REQ_TRANSLATE, '0, '0, '0);
        send_request(REQ_MAP, '0, '1, '1);
        send_request(REQ_TRANSLATE, 48'h0000_0000_0ABC, '0, '0);
        send_request(REQ_MAP, '0, 52'h12345678, 12'h002);
        send_request(REQ_MAP, va_top, '1, 12'h000);
        send_request(REQ_TRANSLATE, va_top, '0, '0);
        send_request(REQ_SET, va_top, '0, 12'hFFE);
        send_request(REQ_CLEAR, va_top, '0, 12'h7FE);
        send_request(REQ_TRANSLATE, va_top, '0, '0);
        send_request(REQ_CLEAR, va_top, '0, 12'h001);
        send_request(REQ_TRANSLATE, va_top, '0, '0);
        send_request(REQ_SET, va_top, '0, 12'h001);
        send_request(REQ_UNMAP, '0, '0, '0);
        send_request(REQ_UNMAP, '0, '0, '0);
        send_request(REQ_SET, '0, '0, 12'hFFF);
        send_request(REQ_CLEAR, 48'h0000_0000_1000, '0, '1);
        for (int op = REQ_BAD; op <= 7; op++)
            send_request(3'(op), va_top, '1, '1);
        send_request(REQ_MAP, 48'h0000_0000_1000, 52'hFFFFF_FFFF_F000, 12'hAAA);
        send_request(REQ_TRANSLATE, 48'h0000_0000_1FFF, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic(int n_items);
        logic [2:0] op;
        logic [VA_W-1:0] va;
        int burst;
        int k;
        k = 0;
        while (k < n_items)
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && k < n_items; b++)
            begin
                if (va_pool.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    va = va_pool[$urandom_range(0, va_pool.size() - 1)];
                    va[11:0] = 12'($urandom);
                    if ($urandom_range(0, 9) == 0)
                        va[20:12] = 9'($urandom);
                end
                else
                    va = rand_va();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:  op = REQ_MAP;
                    5, 6:           op = REQ_UNMAP;
                    7, 8, 9, 10, 11: op = REQ_TRANSLATE;
                    12, 13, 14:     op = REQ_SET;
                    15, 16, 17:     op = REQ_CLEAR;
                    default:        op = 3'($urandom_range(REQ_BAD, 7));
                endcase
                if (op == REQ_MAP && va_pool.size() < 64)
                    va_pool.push_back(va);
                send_request(op, va, rand_pa(), 12'($urandom));
                if (op <= REQ_CLEAR)
                    k++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 12));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 12; i++)
            send_request(REQ_TRANSLATE, va_pool.size() ? va_pool[0] : rand_va(), '0, '0);
        wait_drained();
        drain_stall_on = 1'b0;
        for (int i = 0; i < 20; i++)
            send_request(REQ_SET, va_pool.size() ? va_pool[i % va_pool.size()] : '0, '0,
                         12'($urandom));
        drain_stall_on = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.req_type = '0;
        req.virt_addr = '0;
        req.phys_addr = '0;
        req.flag_bits = '0;
        for (int i = 0; i < N_TBL * 512; i++)
            pt_mem[i] = '0;
        for (int t = 0; t < N_TBL; t++)
            pt_used[t] = (t == 0);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_traffic(1000);
        test_backpressure();
        test_random_traffic(1000);
        repeat (40) @(negedge clk);
        $display("sent %0d request beats, checked %0d response beats", beats_sent,
                 beats_checked);
        $display("overwrites %0d, not mapped %0d, out of tables %0d", n_overwrite,
                 n_not_mapped, n_out_of_tables);
        if (errors == 0 && expected_walks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
